// ===== rtl/lru_key_value_cache_assert.svh =====
// Assertion macros for the cache RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define LKVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lkvc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define LKVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lkvc assertion failed");

`endif

// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// No dependencies; imported by every cache module.
package lkvc_pkg;

    localparam int ENTRIES_DEFAULT = 16;
    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = '1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        logic hit;
        logic evict;
        logic insert;
    } t_lookup_status;

endpackage

// ===== rtl/lkvc_lookup.sv =====
// Parallel key compare, eviction pick and free-slot pick for one request.
// Depends on lkvc_pkg; instantiated by lru_key_value_cache.
module lkvc_lookup import lkvc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
    input  t_op                            i_op,
    input  logic [KEY_W-1:0]               i_key,
    input  logic [CAP_W-1:0]               i_cap,
    input  logic [ENTRIES-1:0][KEY_W-1:0]  i_keys,
    input  logic [ENTRIES-1:0][VAL_W-1:0]  i_values,
    input  logic [ENTRIES-1:0]             i_valid,
    input  logic [ENTRIES-1:0][RANK_W-1:0] i_ranks,
    input  logic [OCC_W-1:0]               i_occ,
    output logic [ENTRIES-1:0]             o_hit_vec,
    output logic [ENTRIES-1:0]             o_evict_vec,
    output logic [ENTRIES-1:0]             o_free_vec,
    output logic [RANK_W-1:0]              o_hit_rank,
    output logic [VAL_W-1:0]               o_read_value,
    output t_lookup_status                 o_status
);

    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

    logic [ENTRIES-1:0] avail;
    logic [VAL_W-1:0]   hit_value;
    logic [CMP_W-1:0]   occ_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic [RANK_W-1:0]  oldest_rank;
    logic               hit;
    logic               full;
    logic               put_miss;

    always_comb begin
        hit_value  = '0;
        o_hit_rank = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            o_hit_vec[i] = i_valid[i] && (i_keys[i] == i_key);
            if (o_hit_vec[i]) begin
                hit_value  = hit_value | i_values[i];
                o_hit_rank = o_hit_rank | i_ranks[i];
            end
        end
    end

    assign hit         = |o_hit_vec;
    assign occ_ext     = CMP_W'(i_occ);
    assign cap_ext     = (i_cap == '0) ? CMP_W'(1) : CMP_W'(i_cap);
    assign full        = (occ_ext >= cap_ext) || (occ_ext >= CMP_W'(ENTRIES));
    assign put_miss    = (i_op == OP_PUT) && !hit;
    assign oldest_rank = RANK_W'(i_occ - OCC_W'(1));

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            o_evict_vec[i] = put_miss && full && i_valid[i] && (i_ranks[i] == oldest_rank);
        end
    end

    // lowest free slot after the eviction
    assign avail      = ~i_valid | o_evict_vec;
    assign o_free_vec = avail & (~avail + ENTRIES'(1));

    assign o_status.hit    = hit;
    assign o_status.evict  = |o_evict_vec;
    assign o_status.insert = put_miss && (|avail);

    assign o_read_value = (i_op == OP_PUT) ? '0 : (hit ? hit_value : MISS_VALUE);

endmodule

// ===== rtl/lkvc_store.sv =====
// Entry storage: keys, values, valid marks, recency ranks and occupancy.
// Depends on lkvc_pkg and the assertion header; instantiated by lru_key_value_cache.
`include "lru_key_value_cache_assert.svh"

module lkvc_store import lkvc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int RANK_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    parameter int OCC_W   = $clog2(ENTRIES + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_upd,
    input  t_op                            i_op,
    input  logic [KEY_W-1:0]               i_key,
    input  logic [VAL_W-1:0]               i_value,
    input  logic [ENTRIES-1:0]             i_hit_vec,
    input  logic [ENTRIES-1:0]             i_evict_vec,
    input  logic [ENTRIES-1:0]             i_free_vec,
    input  logic [RANK_W-1:0]              i_hit_rank,
    input  t_lookup_status                 i_status,
    output logic [ENTRIES-1:0][KEY_W-1:0]  o_keys,
    output logic [ENTRIES-1:0][VAL_W-1:0]  o_values,
    output logic [ENTRIES-1:0]             o_valid,
    output logic [ENTRIES-1:0][RANK_W-1:0] o_ranks,
    output logic [OCC_W-1:0]               o_occ
);

    logic [ENTRIES-1:0][KEY_W-1:0]  r_keys;
    logic [ENTRIES-1:0][VAL_W-1:0]  r_values;
    logic [ENTRIES-1:0]             r_valid;
    logic [ENTRIES-1:0][RANK_W-1:0] r_ranks;
    logic [OCC_W-1:0]               r_occ;

    logic [ENTRIES-1:0]             n_valid;
    logic [ENTRIES-1:0][RANK_W-1:0] n_ranks;
    logic [OCC_W-1:0]               n_occ;

    always_comb begin
        n_valid = r_valid;
        n_ranks = r_ranks;
        n_occ   = r_occ;
        if (i_status.hit) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_hit_vec[i]) begin
                    n_ranks[i] = '0;
                end else if (r_valid[i] && (r_ranks[i] < i_hit_rank)) begin
                    n_ranks[i] = r_ranks[i] + RANK_W'(1);
                end
            end
        end else if (i_status.insert) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_free_vec[i]) begin
                    n_valid[i] = 1'b1;
                    n_ranks[i] = '0;
                end else if (i_evict_vec[i]) begin
                    n_valid[i] = 1'b0;
                    n_ranks[i] = '0;
                end else if (r_valid[i]) begin
                    n_ranks[i] = r_ranks[i] + RANK_W'(1);
                end
            end
            if (!i_status.evict) begin
                n_occ = r_occ + OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ranks <= '0;
            r_occ   <= '0;
        end else if (i_upd) begin
            r_valid <= n_valid;
            r_ranks <= n_ranks;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_status.insert && i_free_vec[i]) begin
                    r_keys[i]   <= i_key;
                    r_values[i] <= i_value;
                end else if ((i_op == OP_PUT) && i_hit_vec[i]) begin
                    r_values[i] <= i_value;
                end
            end
        end
    end

    assign o_keys   = r_keys;
    assign o_values = r_values;
    assign o_valid  = r_valid;
    assign o_ranks  = r_ranks;
    assign o_occ    = r_occ;

    `LKVC_ASSERT_IMP(a_occ_matches_valid, i_clk, i_rst_n, 1'b1, $countones(r_valid) == int'(r_occ))
    `LKVC_ASSERT_IMP(a_single_hit, i_clk, i_rst_n, i_upd, $onehot0(i_hit_vec))
    `LKVC_ASSERT_IMP(a_single_victim, i_clk, i_rst_n, i_upd && i_status.evict, $onehot(i_evict_vec))
    `LKVC_ASSERT_NXT(a_insert_grows, i_clk, i_rst_n, i_upd && i_status.insert && !i_status.evict, r_occ == $past(r_occ) + OCC_W'(1))

endmodule

// ===== rtl/lru_key_value_cache.sv =====
// Fully associative LRU key/value cache, one request per cycle unless the output stalls.
// An accepted request waits in the request register, and its result is registered in
// the result register once that is empty or being read. Throughput: one request per
// cycle unless the output stalls, set by the combinational key compare and rank update.
// Reset (synchronous, active low) clears valid marks, ranks, occupancy and handshake
// state, and sets the capacity register to 16; no clearing pass is needed.
module lru_key_value_cache import lkvc_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEFAULT
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CAP_W-1:0]       i_cfg_wdata,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [2*KEY_W-1:0]     i_s_axis_tdata,  // lookup_key, write_value
    input  logic [0:0]             i_s_axis_tuser,  // operation
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [VAL_W-1:0]       o_m_axis_tdata,  // read_value
    output logic [1:0]             o_m_axis_tuser   // found, evicted
);

    localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W  = $clog2(ENTRIES + 1);

    logic [CAP_W-1:0] r_cap;
    logic             r_req_valid;
    t_op              r_req_op;
    logic [KEY_W-1:0] r_req_key;
    logic [VAL_W-1:0] r_req_value;
    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_data;
    logic [1:0]       r_out_user;

    logic                           advance;
    logic [ENTRIES-1:0][KEY_W-1:0]  keys;
    logic [ENTRIES-1:0][VAL_W-1:0]  values;
    logic [ENTRIES-1:0]             valid;
    logic [ENTRIES-1:0][RANK_W-1:0] ranks;
    logic [OCC_W-1:0]               occ;
    logic [ENTRIES-1:0]             hit_vec;
    logic [ENTRIES-1:0]             evict_vec;
    logic [ENTRIES-1:0]             free_vec;
    logic [RANK_W-1:0]              hit_rank;
    logic [VAL_W-1:0]               read_value;
    t_lookup_status                 status;

    assign advance         = r_req_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_req_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_req_valid <= i_s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_req_op    <= t_op'(i_s_axis_tuser[0]);
            r_req_key   <= i_s_axis_tdata[KEY_W-1:0];
            r_req_value <= i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
        end
        if (advance) begin
            r_out_data <= read_value;
            r_out_user <= {status.evict, status.hit};
        end
    end

    lkvc_lookup #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .OCC_W   (OCC_W)
    ) u_lookup (
        .i_op         (r_req_op),
        .i_key        (r_req_key),
        .i_cap        (r_cap),
        .i_keys       (keys),
        .i_values     (values),
        .i_valid      (valid),
        .i_ranks      (ranks),
        .i_occ        (occ),
        .o_hit_vec    (hit_vec),
        .o_evict_vec  (evict_vec),
        .o_free_vec   (free_vec),
        .o_hit_rank   (hit_rank),
        .o_read_value (read_value),
        .o_status     (status)
    );

    lkvc_store #(
        .ENTRIES (ENTRIES),
        .RANK_W  (RANK_W),
        .OCC_W   (OCC_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_upd       (advance),
        .i_op        (r_req_op),
        .i_key       (r_req_key),
        .i_value     (r_req_value),
        .i_hit_vec   (hit_vec),
        .i_evict_vec (evict_vec),
        .i_free_vec  (free_vec),
        .i_hit_rank  (hit_rank),
        .i_status    (status),
        .o_keys      (keys),
        .o_values    (values),
        .o_valid     (valid),
        .o_ranks     (ranks),
        .o_occ       (occ)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

endmodule
